[rtl/core/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, widths, constants and helpers of the barometric sensor
// compensation unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// sensor read fields
	localparam int IN_W      = 24;
	localparam int RAW_WIDTH = 24;

	// result fields
	localparam int STAT_W = 2;
	localparam int TEMP_W = 16;
	localparam int PRES_W = 28;

	// fixed point: scaled raw values are Q22, pressure terms Pa in Q8
	localparam int QBITS   = 22;
	localparam int T_SHIFT = 14;
	localparam int ACC_W   = 37;
	localparam int SC_W    = 29;
	localparam int PROD_W  = ACC_W + SC_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int MAG_W   = ACC_W - 1;

	localparam logic signed [63:0] ACC_LIM = 64'sd34359738368;

	localparam logic signed [TEMP_W-1:0] HELD_T_RST = 16'sd6400;
	localparam logic signed [PRES_W-1:0] HELD_P_RST = 28'sd66404352;

	// shared divider
	localparam int DIV_NUM_W = 44;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_ITER  = DIV_NUM_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	// pa (q8) to hpa (16 fraction bits): round(p * 256 / 100) as (128|p| + 25) / 50
	localparam int                   H_SHIFT = 7;
	localparam int                   H_BIAS  = 25;
	localparam logic [DIV_DEN_W-1:0] H_DEN   = 9'd50;

	// configuration port
	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;

	localparam logic [2:0] REG_C0_C1    = 3'd0;
	localparam logic [2:0] REG_C00_C10  = 3'd1;
	localparam logic [2:0] REG_C01_C11  = 3'd2;
	localparam logic [2:0] REG_C20_C21  = 3'd3;
	localparam logic [2:0] REG_C30      = 3'd4;
	localparam logic [2:0] REG_PRS_OSR  = 3'd5;
	localparam logic [2:0] REG_TMP_OSR  = 3'd6;

	localparam logic [2:0] OSR_RST = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_BUS_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] numer;
		logic [DIV_DEN_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	// sign extension from bit RAW_WIDTH-1
	function automatic logic signed [IN_W-1:0] raw_sext(input logic [IN_W-1:0] v);
		logic signed [IN_W-1:0] t;
		t = signed'(v << (IN_W - RAW_WIDTH));
		return t >>> (IN_W - RAW_WIDTH);
	endfunction

	function automatic logic [IN_W-1:0] raw_mag(input logic signed [IN_W-1:0] v);
		return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
	endfunction

	// scale divisor k = odd * 2^(23 - s), s being the shift below:
	// 524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
	function automatic logic [7:0] osr_odd(input logic [2:0] code);
		logic [7:0] m;
		case (code)
			3'd0:    m = 8'd1;
			3'd1:    m = 8'd3;
			3'd2:    m = 8'd7;
			3'd3:    m = 8'd15;
			3'd4:    m = 8'd31;
			3'd5:    m = 8'd63;
			3'd6:    m = 8'd127;
			default: m = 8'd255;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] osr_shift(input logic [2:0] code);
		return code[2] ? 4'd10 : 4'd4;
	endfunction

	// round(|raw| * 2^22 / k) = floor((2 * |raw| * 2^22 / k * odd + odd) / (2 * odd))
	function automatic logic [DIV_NUM_W-1:0] scale_numer(input logic [IN_W-1:0] mag,
			input logic [2:0] code);
		return (DIV_NUM_W'(mag) << osr_shift(code)) + DIV_NUM_W'(osr_odd(code));
	endfunction

	function automatic logic [DIV_DEN_W-1:0] scale_denom(input logic [2:0] code);
		return {osr_odd(code), 1'b0};
	endfunction

endpackage

[rtl/core/bsc_if.sv]
// ----------------------------------------------------------------------------
// bsc_sample_if / bsc_result_if
// Valid/ready channels for sensor reads and compensated results.
// ----------------------------------------------------------------------------
interface bsc_sample_if import bsc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   bus_error;
	logic                   pressure_ready;
	logic                   temperature_ready;
	logic signed [IN_W-1:0] raw_pressure;
	logic signed [IN_W-1:0] raw_temperature;

	modport source (
		output valid, bus_error, pressure_ready, temperature_ready,
			raw_pressure, raw_temperature,
		input  ready
	);
	modport sink (
		input  valid, bus_error, pressure_ready, temperature_ready,
			raw_pressure, raw_temperature,
		output ready
	);
endinterface

interface bsc_result_if import bsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [TEMP_W-1:0] temperature_out;
	logic signed [PRES_W-1:0] pressure_out;

	modport source (
		output valid, status, temperature_out, pressure_out,
		input  ready
	);
	modport sink (
		input  valid, status, temperature_out, pressure_out,
		output ready
	);
endinterface

[rtl/core/bsc_div.sv]
// ----------------------------------------------------------------------------
// bsc_div
// Unsigned restoring divider, two quotient bits per cycle, shared by the
// raw scaling and the pascal to hectopascal conversion.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   r1, r2, r1n, r2n;
	logic                 ge1, ge2;

	// two dependent compare/subtract steps on narrow remainders
	always_comb begin
		r1  = {rem_q, num_q[DIV_NUM_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1n = ge1 ? r1 - {1'b0, den_q} : r1;
		r2  = {r1n[DIV_DEN_W-1:0], num_q[DIV_NUM_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2n = ge2 ? r2 - {1'b0, den_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= DIV_CNT_W'(DIV_ITER);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in from the bottom as the dividend shifts out
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.numer;
			den_q <= req.denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-3:0], ge1, ge2};
			rem_q <= r2n[DIV_DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

[rtl/core/baro_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Compensates raw barometer reads into degrees C (Q8.8) and hPa (16 fraction
// bits) with calibration polynomials; holds the last good values.
// ----------------------------------------------------------------------------
// Usage:
//  sample carries one sensor read (flags and raw codes), result returns one
//  item per read: status, temperature_out and pressure_out. Both are
//  valid/ready channels; an item moves on a transfer (valid and ready high).
//  Calibration words and oversampling codes are written over the apb port;
//  the user must write them only while the unit is idle, as the unit itself
//  does not enforce this. Register i sits at byte address 8*i.
//  A bus error or a read with no ready flag skips the arithmetic and goes
//  straight to the result stage. Otherwise the shared two-bit-per-cycle
//  divider scales the raw pressure, then the raw temperature; for a pressure
//  read the shared 37x29 multiplier runs the Horner steps, each a multiply
//  and an add state, and the divider converts the sum to hPa; for a
//  temperature read a last multiply and add give degrees C.
//  sample.ready is high only while no read is in work; a new read is taken
//  while the previous result still waits in the output register.
//  If the receiver stalls, a finished result waits in the sequencer until
//  the output register frees up.
//  Reset returns the calibration registers to zero, both oversampling codes
//  to 4 and the held values to 25.0 C and 1013.25 hPa.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit import bsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	bsc_sample_if.sink        sample,
	bsc_result_if.source      result
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DIVP   = 11'b000_0000_0010,
		S_DIVT   = 11'b000_0000_0100,
		S_MUL    = 11'b000_0000_1000,
		S_ADD    = 11'b000_0001_0000,
		S_SUM    = 11'b000_0010_0000,
		S_HSTART = 11'b000_0100_0000,
		S_HDIV   = 11'b000_1000_0000,
		S_TMUL   = 11'b001_0000_0000,
		S_TADD   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	// horner steps: three on the pressure chain, two on the temperature
	// cross term, then the cross term scaled by tsc
	localparam logic [2:0] STEP_FIRST_T = 3'd3;
	localparam logic [2:0] STEP_LAST    = 3'd5;

	localparam int SSUM_W = ACC_W + 1;

	localparam logic signed [SUM_W-1:0] RB22_P  = SUM_W'(2**(QBITS - 1));
	localparam logic signed [SUM_W-1:0] RB22_N  = RB22_P - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] RB14_P  = SUM_W'(2**(T_SHIFT - 1));
	localparam logic signed [SUM_W-1:0] RB14_N  = RB14_P - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] H_MAX   = SUM_W'(ACC_LIM);
	localparam logic signed [SUM_W-1:0] H_MIN   = -H_MAX;
	localparam logic signed [SUM_W-1:0] T_MAX   = SUM_W'(2**(TEMP_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] T_MIN   = -T_MAX - SUM_W'(1);
	localparam logic [DIV_NUM_W-1:0]    P_POS_LIM = DIV_NUM_W'(2**(PRES_W - 1) - 1);
	localparam logic [DIV_NUM_W-1:0]    P_NEG_LIM = DIV_NUM_W'(2**(PRES_W - 1));

	state_t state_q;
	logic [2:0] step_q;

	// configuration
	logic [23:0] cfg_c0c1_q;
	logic [39:0] cfg_c00c10_q;
	logic [31:0] cfg_c01c11_q;
	logic [31:0] cfg_c20c21_q;
	logic [15:0] cfg_c30_q;
	logic [2:0]  prs_osr_q;
	logic [2:0]  tmp_osr_q;
	logic [2:0]  cfg_idx;
	logic        cfg_wr;

	logic signed [11:0] c0, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;

	// held values and output register
	logic signed [TEMP_W-1:0] held_t_q;
	logic signed [PRES_W-1:0] held_p_q;
	logic                     out_valid_q;
	status_t                  out_stat_q;
	logic signed [TEMP_W-1:0] out_t_q;
	logic signed [PRES_W-1:0] out_p_q;

	// per-read working registers
	status_t                  stat_q;
	logic                     prdy_q, trdy_q;
	logic signed [IN_W-1:0]   traw_q;
	logic                     sign_q;
	logic signed [SC_W-1:0]   psc_q, tsc_q;
	logic signed [ACC_W-1:0]  acc_q, t_q;
	logic signed [PROD_W-1:0] prod_q;

	logic                     accept, compute, out_load;
	logic signed [IN_W-1:0]   praw_in;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	logic                     div_sign;
	logic [MAG_W-1:0]         acc_mag;
	logic signed [SC_W-1:0]   sc_val;

	logic signed [ACC_W-1:0]  mul_a;
	logic signed [SC_W-1:0]   mul_b;
	logic signed [19:0]       coef_sel;
	logic signed [SUM_W-1:0]  hx, hy, tx, ty;
	logic signed [ACC_W-1:0]  horner_res;
	logic signed [SSUM_W-1:0] psum;
	logic signed [ACC_W-1:0]  psum_sat;
	logic signed [TEMP_W-1:0] temp_sat;
	logic signed [PRES_W-1:0] pres_sat;

	assign c0  = signed'(cfg_c0c1_q[23:12]);
	assign c1  = signed'(cfg_c0c1_q[11:0]);
	assign c00 = signed'(cfg_c00c10_q[39:20]);
	assign c10 = signed'(cfg_c00c10_q[19:0]);
	assign c01 = signed'(cfg_c01c11_q[31:16]);
	assign c11 = signed'(cfg_c01c11_q[15:0]);
	assign c20 = signed'(cfg_c20c21_q[31:16]);
	assign c21 = signed'(cfg_c20c21_q[15:0]);
	assign c30 = signed'(cfg_c30_q);

	// apb port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_AW-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_C0_C1:   prdata = CFG_DW'(cfg_c0c1_q);
			REG_C00_C10: prdata = CFG_DW'(cfg_c00c10_q);
			REG_C01_C11: prdata = CFG_DW'(cfg_c01c11_q);
			REG_C20_C21: prdata = CFG_DW'(cfg_c20c21_q);
			REG_C30:     prdata = CFG_DW'(cfg_c30_q);
			REG_PRS_OSR: prdata = CFG_DW'(prs_osr_q);
			REG_TMP_OSR: prdata = CFG_DW'(tmp_osr_q);
			default:     prdata = '0;
		endcase
	end

	// handshakes
	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign compute      = !sample.bus_error && (sample.pressure_ready || sample.temperature_ready);
	assign praw_in      = raw_sext(sample.raw_pressure);
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || result.ready);

	assign result.valid           = out_valid_q;
	assign result.status          = out_stat_q;
	assign result.temperature_out = out_t_q;
	assign result.pressure_out    = out_p_q;

	// divider requests
	assign acc_mag = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);

	always_comb begin
		div_req  = '0;
		div_sign = 1'b0;
		case (state_q)
			S_IDLE: begin
				div_req.start = accept && compute;
				div_req.numer = scale_numer(raw_mag(praw_in), prs_osr_q);
				div_req.denom = scale_denom(prs_osr_q);
				div_sign      = praw_in[IN_W-1];
			end
			S_DIVP: begin
				div_req.start = div_rsp.done;
				div_req.numer = scale_numer(raw_mag(traw_q), tmp_osr_q);
				div_req.denom = scale_denom(tmp_osr_q);
				div_sign      = traw_q[IN_W-1];
			end
			S_HSTART: begin
				div_req.start = 1'b1;
				div_req.numer = (DIV_NUM_W'(acc_mag) << H_SHIFT) + DIV_NUM_W'(H_BIAS);
				div_req.denom = H_DEN;
				div_sign      = acc_q[ACC_W-1];
			end
			default: ;
		endcase
	end

	bsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// scaled raw value, magnitude below 2^28
	assign sc_val = sign_q ? -signed'(div_rsp.quo[SC_W-1:0]) : signed'(div_rsp.quo[SC_W-1:0]);

	// shared multiplier operands
	always_comb begin
		if (state_q == S_TMUL) begin
			mul_a = ACC_W'(c1);
		end else if (step_q < STEP_FIRST_T) begin
			mul_a = acc_q;
		end else begin
			mul_a = t_q;
		end
		mul_b = (state_q == S_TMUL || step_q == STEP_LAST) ? tsc_q : psc_q;
	end

	always_comb begin
		case (step_q)
			3'd0:    coef_sel = 20'(c20);
			3'd1:    coef_sel = c10;
			3'd2:    coef_sel = c00;
			3'd3:    coef_sel = 20'(c11);
			3'd4:    coef_sel = 20'(c01);
			default: coef_sel = '0;
		endcase
	end

	// round half away from zero folded into one add: bias is half, less one
	// for a negative product; the coefficient rides above the dropped bits
	always_comb begin
		hx = SUM_W'(prod_q) + (prod_q[PROD_W-1] ? RB22_N : RB22_P)
			+ (SUM_W'(coef_sel) <<< (QBITS + 8));
		hy = hx >>> QBITS;
		if (hy > H_MAX) begin
			horner_res = ACC_W'(H_MAX);
		end else if (hy < H_MIN) begin
			horner_res = ACC_W'(H_MIN);
		end else begin
			horner_res = ACC_W'(hy);
		end

		tx = SUM_W'(prod_q) + (prod_q[PROD_W-1] ? RB14_N : RB14_P)
			+ (SUM_W'(c0) <<< (T_SHIFT + 7));
		ty = tx >>> T_SHIFT;
		if (ty > T_MAX) begin
			temp_sat = TEMP_W'(T_MAX);
		end else if (ty < T_MIN) begin
			temp_sat = TEMP_W'(T_MIN);
		end else begin
			temp_sat = TEMP_W'(ty);
		end

		psum = SSUM_W'(acc_q) + SSUM_W'(t_q);
		if (psum > SSUM_W'(ACC_LIM)) begin
			psum_sat = ACC_W'(ACC_LIM);
		end else if (psum < -SSUM_W'(ACC_LIM)) begin
			psum_sat = -ACC_W'(ACC_LIM);
		end else begin
			psum_sat = ACC_W'(psum);
		end

		if (!sign_q) begin
			pres_sat = (div_rsp.quo > P_POS_LIM) ? PRES_W'(P_POS_LIM) : PRES_W'(div_rsp.quo);
		end else begin
			pres_sat = (div_rsp.quo > P_NEG_LIM) ? -PRES_W'(P_NEG_LIM)
				: -PRES_W'(div_rsp.quo);
		end
	end

	// sequencer, held values and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			held_t_q     <= HELD_T_RST;
			held_p_q     <= HELD_P_RST;
			cfg_c0c1_q   <= '0;
			cfg_c00c10_q <= '0;
			cfg_c01c11_q <= '0;
			cfg_c20c21_q <= '0;
			cfg_c30_q    <= '0;
			prs_osr_q    <= OSR_RST;
			tmp_osr_q    <= OSR_RST;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_C0_C1:   cfg_c0c1_q   <= pwdata[23:0];
					REG_C00_C10: cfg_c00c10_q <= pwdata[39:0];
					REG_C01_C11: cfg_c01c11_q <= pwdata[31:0];
					REG_C20_C21: cfg_c20c21_q <= pwdata[31:0];
					REG_C30:     cfg_c30_q    <= pwdata[15:0];
					REG_PRS_OSR: prs_osr_q    <= pwdata[2:0];
					REG_TMP_OSR: tmp_osr_q    <= pwdata[2:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= compute ? S_DIVP : S_DONE;
					end
				end
				S_DIVP: begin
					if (div_rsp.done) begin
						state_q <= S_DIVT;
					end
				end
				S_DIVT: begin
					if (div_rsp.done) begin
						step_q  <= '0;
						state_q <= prdy_q ? S_MUL : S_TMUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (step_q == STEP_LAST) begin
						state_q <= S_SUM;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_SUM: begin
					state_q <= S_HSTART;
				end
				S_HSTART: begin
					state_q <= S_HDIV;
				end
				S_HDIV: begin
					if (div_rsp.done) begin
						held_p_q <= pres_sat;
						state_q  <= trdy_q ? S_TMUL : S_DONE;
					end
				end
				S_TMUL: begin
					state_q <= S_TADD;
				end
				S_TADD: begin
					held_t_q <= temp_sat;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			prdy_q <= sample.pressure_ready;
			trdy_q <= sample.temperature_ready;
			traw_q <= raw_sext(sample.raw_temperature);
			acc_q  <= ACC_W'(c30) <<< 8;
			t_q    <= ACC_W'(c21) <<< 8;
			if (sample.bus_error) begin
				stat_q <= ST_BUS_ERR;
			end else if (!compute) begin
				stat_q <= ST_BUSY;
			end else begin
				stat_q <= ST_OK;
			end
		end

		if (div_req.start) begin
			sign_q <= div_sign;
		end

		if (state_q == S_DIVP && div_rsp.done) begin
			psc_q <= sc_val;
		end
		if (state_q == S_DIVT && div_rsp.done) begin
			tsc_q <= sc_val;
		end

		if (state_q == S_MUL || state_q == S_TMUL) begin
			prod_q <= mul_a * mul_b;
		end

		if (state_q == S_ADD) begin
			if (step_q < STEP_FIRST_T) begin
				acc_q <= horner_res;
			end else begin
				t_q <= horner_res;
			end
		end

		if (state_q == S_SUM) begin
			acc_q <= psum_sat;
		end

		if (out_load) begin
			out_stat_q <= stat_q;
			out_t_q    <= held_t_q;
			out_p_q    <= held_p_q;
		end
	end

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_rsp.busy)
		else $error("divider busy while sequencer idle");

	a_bus_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.bus_error) |=> (state_q == S_DONE && stat_q == ST_BUS_ERR))
		else $error("bus error read did not go straight to result");

	a_held_p_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_p_q) |-> $past(state_q == S_HDIV && div_rsp.done))
		else $error("held pressure changed outside conversion end");
`endif

endmodule
